// ----- rtl/oit_pkg.sv -----
package oit_pkg;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_ACK    = 3'd1;
    localparam logic [2:0] KIND_CLOSE  = 3'd2;
    localparam logic [2:0] KIND_CANCEL = 3'd3;
    localparam logic [2:0] KIND_FIND_C = 3'd4;
    localparam logic [2:0] KIND_FIND_X = 3'd5;

    localparam logic [2:0] RC_OK            = 3'd0;
    localparam logic [2:0] RC_INVALID       = 3'd1;
    localparam logic [2:0] RC_DUP           = 3'd2;
    localparam logic [2:0] RC_EXHAUSTED     = 3'd3;
    localparam logic [2:0] RC_NOT_FOUND     = 3'd4;
    localparam logic [2:0] RC_NOT_SUPPORTED = 3'd5;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_LIVE    = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] client_id;
        logic [63:0] exchange_id;
        logic        accepted;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  entry_state;
        logic [63:0] found_client_id;
        logic [63:0] found_exchange_id;
        logic [63:0] found_sequence;
        logic [6:0]  used_slots;
        logic [6:0]  live_orders;
    } res_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic        cl_hit;
        logic [1:0]  cl_state;
        logic [63:0] cl_client;
        logic [63:0] cl_exch;
        logic [63:0] cl_seq;
        logic        xh_hit;
        logic [1:0]  xh_state;
        logic [63:0] xh_client;
        logic [63:0] xh_exch;
        logic [63:0] xh_seq;
        logic        em_hit;
        logic        dn_hit;
        logic [63:0] dn_seq;
    } tok_t;

    typedef struct packed {
        logic        en;
        logic [1:0]  state;
        logic        set_client;
        logic [63:0] client;
        logic        set_exch;
        logic [63:0] exch;
        logic        set_seq;
        logic [63:0] seq;
    } wr_t;

endpackage

// ----- rtl/oit_cell.sv -----
module oit_cell #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7,
    parameter int SLOT  = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         q_client,
    input  logic [63:0]         q_exch,
    input  oit_pkg::tok_t       tok_in,
    input  logic [IDX_W-1:0]    cl_idx_in,
    input  logic [IDX_W-1:0]    em_idx_in,
    input  logic [IDX_W-1:0]    dn_idx_in,
    input  logic [CNT_W-1:0]    live_in,
    output oit_pkg::tok_t       tok_out,
    output logic [IDX_W-1:0]    cl_idx_out,
    output logic [IDX_W-1:0]    em_idx_out,
    output logic [IDX_W-1:0]    dn_idx_out,
    output logic [CNT_W-1:0]    live_out,
    input  oit_pkg::wr_t        wr,
    input  logic [IDX_W-1:0]    wr_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT);

    logic [1:0]       state_reg;
    logic [63:0]      client_reg;
    logic [63:0]      exch_reg;
    logic [63:0]      seq_reg;
    oit_pkg::tok_t    tok_reg, tok_next;
    logic [IDX_W-1:0] cl_idx_reg, cl_idx_next;
    logic [IDX_W-1:0] em_idx_reg, em_idx_next;
    logic [IDX_W-1:0] dn_idx_reg, dn_idx_next;
    logic [CNT_W-1:0] live_reg, live_next;

    always_comb
    begin
        tok_next    = tok_in;
        cl_idx_next = cl_idx_in;
        em_idx_next = em_idx_in;
        dn_idx_next = dn_idx_in;
        live_next   = live_in;
        if (!tok_in.cl_hit && state_reg != oit_pkg::ST_EMPTY && client_reg == q_client)
        begin
            tok_next.cl_hit    = 1'b1;
            tok_next.cl_state  = state_reg;
            tok_next.cl_client = client_reg;
            tok_next.cl_exch   = exch_reg;
            tok_next.cl_seq    = seq_reg;
            cl_idx_next        = MY_IDX;
        end
        if (!tok_in.xh_hit && exch_reg == q_exch)
        begin
            tok_next.xh_hit    = 1'b1;
            tok_next.xh_state  = state_reg;
            tok_next.xh_client = client_reg;
            tok_next.xh_exch   = exch_reg;
            tok_next.xh_seq    = seq_reg;
        end
        if (!tok_in.em_hit && state_reg == oit_pkg::ST_EMPTY)
        begin
            tok_next.em_hit = 1'b1;
            em_idx_next     = MY_IDX;
        end
        // strict compare keeps the lowest index on a tie
        if (state_reg == oit_pkg::ST_DONE && (!tok_in.dn_hit || seq_reg < tok_in.dn_seq))
        begin
            tok_next.dn_hit = 1'b1;
            tok_next.dn_seq = seq_reg;
            dn_idx_next     = MY_IDX;
        end
        if (state_reg == oit_pkg::ST_PENDING || state_reg == oit_pkg::ST_LIVE)
        begin
            live_next = live_in + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= oit_pkg::ST_EMPTY;
            client_reg <= '0;
            exch_reg   <= '0;
            seq_reg    <= '0;
        end
        else if (wr.en && wr_idx == MY_IDX)
        begin
            state_reg <= wr.state;
            if (wr.set_client)
            begin
                client_reg <= wr.client;
            end
            if (wr.set_exch)
            begin
                exch_reg <= wr.exch;
            end
            if (wr.set_seq)
            begin
                seq_reg <= wr.seq;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg    <= tok_next;
        cl_idx_reg <= cl_idx_next;
        em_idx_reg <= em_idx_next;
        dn_idx_reg <= dn_idx_next;
        live_reg   <= live_next;
    end

    assign tok_out    = tok_reg;
    assign cl_idx_out = cl_idx_reg;
    assign em_idx_out = em_idx_reg;
    assign dn_idx_out = dn_idx_reg;
    assign live_out   = live_reg;

endmodule

// ----- rtl/order_id_table.sv -----
// Order id table: ENTRIES order slots, each with a state, client id,
// exchange id and insertion sequence, held in a row of cells.
// Command channel: cmd is taken as a transaction at a rising edge with
// start high and busy low. busy stays high until the result is out.
// Result channel: result is shown for exactly one cycle with result_valid
// high; the receiver cannot hold it off, so it never stalls the block.
// Each transaction broadcasts its ids to every cell, then a scan token
// walks the row one cell per clock collecting the first client match, the
// first exchange match, the first empty slot, the oldest done slot and the
// live count. The finish state then decides, writes the chosen cell and
// registers the result. busy drops as result_valid rises, so the next
// transaction can be taken at the edge that ends the result cycle.
// Reset empties every slot, clears used_slots and sets the next sequence
// to one; no clearing pass is needed.
module order_id_table #(
    parameter int ENTRIES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  oit_pkg::cmd_t cmd,
    output logic          result_valid,
    output oit_pkg::res_t result
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } fsm_t;

    fsm_t             state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    oit_pkg::cmd_t    q_reg;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [63:0]      seq_reg, seq_next;
    oit_pkg::res_t    res_reg, res_next;
    logic             res_valid_reg;

    oit_pkg::tok_t    tok  [ENTRIES+1];
    logic [IDX_W-1:0] cl_i [ENTRIES+1];
    logic [IDX_W-1:0] em_i [ENTRIES+1];
    logic [IDX_W-1:0] dn_i [ENTRIES+1];
    logic [CNT_W-1:0] live [ENTRIES+1];

    oit_pkg::wr_t     wr;
    logic [IDX_W-1:0] wr_idx;

    assign tok[0]  = '0;
    assign cl_i[0] = '0;
    assign em_i[0] = '0;
    assign dn_i[0] = '0;
    assign live[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        oit_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .SLOT  (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .q_client   (q_reg.client_id),
            .q_exch     (q_reg.exchange_id),
            .tok_in     (tok[g]),
            .cl_idx_in  (cl_i[g]),
            .em_idx_in  (em_i[g]),
            .dn_idx_in  (dn_i[g]),
            .live_in    (live[g]),
            .tok_out    (tok[g+1]),
            .cl_idx_out (cl_i[g+1]),
            .em_idx_out (em_i[g+1]),
            .dn_idx_out (dn_i[g+1]),
            .live_out   (live[g+1]),
            .wr         (wr),
            .wr_idx     (wr_idx)
        );
    end

    // decide from the token leaving the last cell
    always_comb
    begin
        oit_pkg::tok_t    t;
        logic [CNT_W-1:0] lv;
        logic             was_active;
        t          = tok[ENTRIES];
        lv         = live[ENTRIES];
        was_active = (t.cl_state == oit_pkg::ST_PENDING) || (t.cl_state == oit_pkg::ST_LIVE);
        wr         = '0;
        wr_idx     = cl_i[ENTRIES];
        used_next  = used_reg;
        seq_next   = seq_reg;
        res_next   = '0;
        res_next.status = oit_pkg::RC_OK;
        unique case (q_reg.kind)
            oit_pkg::KIND_ADD:
            begin
                if (q_reg.client_id == 64'd0)
                begin
                    res_next.status = oit_pkg::RC_INVALID;
                end
                else if (t.cl_hit)
                begin
                    res_next.status = oit_pkg::RC_DUP;
                end
                else if (!t.em_hit && !t.dn_hit)
                begin
                    res_next.status = oit_pkg::RC_EXHAUSTED;
                end
                else
                begin
                    if (t.em_hit)
                    begin
                        wr_idx    = em_i[ENTRIES];
                        used_next = used_reg + CNT_W'(1);
                    end
                    else
                    begin
                        wr_idx = dn_i[ENTRIES];
                    end
                    wr.en         = 1'b1;
                    wr.state      = oit_pkg::ST_PENDING;
                    wr.set_client = 1'b1;
                    wr.client     = q_reg.client_id;
                    wr.set_exch   = 1'b1;
                    wr.exch       = '0;
                    wr.set_seq    = 1'b1;
                    wr.seq        = seq_reg;
                    seq_next      = seq_reg + 64'd1;
                    res_next.entry_state     = oit_pkg::ST_PENDING;
                    res_next.found_client_id = q_reg.client_id;
                    res_next.found_sequence  = seq_reg;
                    lv = lv + CNT_W'(1);
                end
            end
            oit_pkg::KIND_ACK:
            begin
                if (!t.cl_hit)
                begin
                    res_next.status = oit_pkg::RC_NOT_FOUND;
                end
                else if (!q_reg.accepted)
                begin
                    wr.en       = 1'b1;
                    wr.state    = oit_pkg::ST_DONE;
                    wr.set_exch = 1'b1;
                    wr.exch     = '0;
                    res_next.entry_state     = oit_pkg::ST_DONE;
                    res_next.found_client_id = t.cl_client;
                    res_next.found_sequence  = t.cl_seq;
                    if (was_active)
                    begin
                        lv = lv - CNT_W'(1);
                    end
                end
                else if (q_reg.exchange_id == 64'd0)
                begin
                    res_next.status = oit_pkg::RC_INVALID;
                end
                else if (t.cl_exch != 64'd0 && t.cl_exch != q_reg.exchange_id)
                begin
                    res_next.status = oit_pkg::RC_DUP;
                end
                else
                begin
                    wr.en       = 1'b1;
                    wr.state    = oit_pkg::ST_LIVE;
                    wr.set_exch = 1'b1;
                    wr.exch     = q_reg.exchange_id;
                    res_next.entry_state       = oit_pkg::ST_LIVE;
                    res_next.found_client_id   = t.cl_client;
                    res_next.found_exchange_id = q_reg.exchange_id;
                    res_next.found_sequence    = t.cl_seq;
                    if (!was_active)
                    begin
                        lv = lv + CNT_W'(1);
                    end
                end
            end
            oit_pkg::KIND_CLOSE:
            begin
                if (!t.cl_hit)
                begin
                    res_next.status = oit_pkg::RC_NOT_FOUND;
                end
                else
                begin
                    wr.en    = 1'b1;
                    wr.state = oit_pkg::ST_DONE;
                    res_next.entry_state       = oit_pkg::ST_DONE;
                    res_next.found_client_id   = t.cl_client;
                    res_next.found_exchange_id = t.cl_exch;
                    res_next.found_sequence    = t.cl_seq;
                    if (was_active)
                    begin
                        lv = lv - CNT_W'(1);
                    end
                end
            end
            oit_pkg::KIND_CANCEL, oit_pkg::KIND_FIND_C:
            begin
                if (!t.cl_hit)
                begin
                    res_next.status = oit_pkg::RC_NOT_FOUND;
                end
                else if (q_reg.kind == oit_pkg::KIND_CANCEL && t.cl_state == oit_pkg::ST_DONE)
                begin
                    res_next.status = oit_pkg::RC_NOT_SUPPORTED;
                end
                else
                begin
                    res_next.entry_state       = t.cl_state;
                    res_next.found_client_id   = t.cl_client;
                    res_next.found_exchange_id = t.cl_exch;
                    res_next.found_sequence    = t.cl_seq;
                end
            end
            oit_pkg::KIND_FIND_X:
            begin
                if (q_reg.exchange_id == 64'd0 || !t.xh_hit)
                begin
                    res_next.status = oit_pkg::RC_NOT_FOUND;
                end
                else
                begin
                    res_next.entry_state       = t.xh_state;
                    res_next.found_client_id   = t.xh_client;
                    res_next.found_exchange_id = t.xh_exch;
                    res_next.found_sequence    = t.xh_seq;
                end
            end
            default:
            begin
                res_next.status = oit_pkg::RC_INVALID;
            end
        endcase
        res_next.used_slots  = 7'(used_next);
        res_next.live_orders = 7'(lv);
        // write only in the decision cycle
        wr.en = wr.en && (state_reg == S_FINISH);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            used_reg      <= '0;
            seq_reg       <= 64'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= (state_reg == S_FINISH);
            if (state_reg == S_FINISH)
            begin
                used_reg <= used_next;
                seq_reg  <= seq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            q_reg <= cmd;
        end
        if (state_reg == S_FINISH)
        begin
            res_reg <= res_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- tb/tb_order_id_table.sv -----
`timescale 1ns / 100ps

module tb_order_id_table;

    localparam int ENTRIES = 64;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    oit_pkg::cmd_t  cmd = '0;
    logic           busy;
    logic           result_valid;
    oit_pkg::res_t  result;

    order_id_table #(.ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .result_valid(result_valid), .result(result)
    );

    always #6 clk = ~clk;

    // table copy used for prediction
    logic [1:0]  tbl_state [ENTRIES];
    logic [63:0] tbl_client [ENTRIES];
    logic [63:0] tbl_exch [ENTRIES];
    logic [63:0] tbl_seq [ENTRIES];
    logic [6:0]  taken_cnt;
    logic [63:0] seq_next;

    oit_pkg::res_t expected_results [$];
    int   mismatches = 0;

    // client ids kept in a small pool so that acks, closes and lookups hit
    logic [63:0] id_pool [16];
    logic [63:0] xid_pool [8];

    function automatic int find_client(logic [63:0] cid);
        if (cid == 0) return -1;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_state[i] != oit_pkg::ST_EMPTY && tbl_client[i] == cid) return i;
        return -1;
    endfunction

    function automatic int find_exch(logic [63:0] xid);
        if (xid == 0) return -1;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_exch[i] == xid) return i;
        return -1;
    endfunction

    function automatic oit_pkg::res_t apply_order_event(oit_pkg::cmd_t c);
        oit_pkg::res_t r;
        int idx;
        int n;
        r = '0;
        r.status = oit_pkg::RC_OK;
        idx = -1;
        case (c.kind)
            oit_pkg::KIND_ADD: begin
                if (c.client_id == 0) r.status = oit_pkg::RC_INVALID;
                else if (find_client(c.client_id) >= 0) r.status = oit_pkg::RC_DUP;
                else begin
                    for (int i = 0; i < ENTRIES && idx < 0; i++)
                        if (tbl_state[i] == oit_pkg::ST_EMPTY) idx = i;
                    if (idx >= 0) taken_cnt++;
                    else begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (tbl_state[i] == oit_pkg::ST_DONE &&
                                (idx < 0 || tbl_seq[i] < tbl_seq[idx])) idx = i;
                    end
                    if (idx < 0) r.status = oit_pkg::RC_EXHAUSTED;
                    else begin
                        tbl_state[idx] = oit_pkg::ST_PENDING;
                        tbl_client[idx] = c.client_id;
                        tbl_exch[idx] = '0;
                        tbl_seq[idx] = seq_next;
                        seq_next++;
                    end
                end
            end
            oit_pkg::KIND_ACK: begin
                idx = find_client(c.client_id);
                if (idx < 0) r.status = oit_pkg::RC_NOT_FOUND;
                else if (!c.accepted) begin
                    tbl_state[idx] = oit_pkg::ST_DONE;
                    tbl_exch[idx] = '0;
                end
                else if (c.exchange_id == 0) r.status = oit_pkg::RC_INVALID;
                else if (tbl_exch[idx] != 0 && tbl_exch[idx] != c.exchange_id)
                    r.status = oit_pkg::RC_DUP;
                else begin
                    tbl_state[idx] = oit_pkg::ST_LIVE;
                    tbl_exch[idx] = c.exchange_id;
                end
            end
            oit_pkg::KIND_CLOSE: begin
                idx = find_client(c.client_id);
                if (idx < 0) r.status = oit_pkg::RC_NOT_FOUND;
                else tbl_state[idx] = oit_pkg::ST_DONE;
            end
            oit_pkg::KIND_CANCEL: begin
                idx = find_client(c.client_id);
                if (idx < 0) r.status = oit_pkg::RC_NOT_FOUND;
                else if (tbl_state[idx] == oit_pkg::ST_DONE)
                    r.status = oit_pkg::RC_NOT_SUPPORTED;
            end
            oit_pkg::KIND_FIND_C: begin
                idx = find_client(c.client_id);
                if (idx < 0) r.status = oit_pkg::RC_NOT_FOUND;
            end
            oit_pkg::KIND_FIND_X: begin
                idx = find_exch(c.exchange_id);
                if (idx < 0) r.status = oit_pkg::RC_NOT_FOUND;
            end
            default: r.status = oit_pkg::RC_INVALID;
        endcase
        if (r.status == oit_pkg::RC_OK && idx >= 0) begin
            r.entry_state = tbl_state[idx];
            r.found_client_id = tbl_client[idx];
            r.found_exchange_id = tbl_exch[idx];
            r.found_sequence = tbl_seq[idx];
        end
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_state[i] == oit_pkg::ST_PENDING || tbl_state[i] == oit_pkg::ST_LIVE) n++;
        r.used_slots = taken_cnt;
        r.live_orders = n[6:0];
        return r;
    endfunction

    task automatic idle_gap();
        int g;
        if ($urandom_range(0, 9) < 4) return;
        g = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
        repeat (g) @(posedge clk);
    endtask

    // send one transaction; start stays high until busy is seen low
    task automatic send_cmd(oit_pkg::cmd_t c);
        cmd <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_results.push_back(apply_order_event(c));
        start <= 1'b0;
        // let the drop of start settle before the next transaction is driven
        @(posedge clk);
    endtask

    task automatic send_op(logic [2:0] k, logic [63:0] cid, logic [63:0] xid, logic acc);
        oit_pkg::cmd_t c;
        c.kind = k;
        c.client_id = cid;
        c.exchange_id = xid;
        c.accepted = acc;
        send_cmd(c);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    always @(posedge clk) begin
        oit_pkg::res_t e;
        if (rst_n && result_valid) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", result);
            end
            else begin
                e = expected_results.pop_front();
                if (result !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", e, result);
                end
            end
        end
    end

    task automatic test_directed();
        send_op(oit_pkg::KIND_ADD, 64'd0, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_ADD, '1, '1, 1'b1);
        send_op(oit_pkg::KIND_ADD, '1, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_ADD, 64'd1, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_CANCEL, '1, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_ACK, '1, 64'd0, 1'b1);
        send_op(oit_pkg::KIND_ACK, '1, '1, 1'b1);
        send_op(oit_pkg::KIND_ACK, '1, 64'd5, 1'b1);
        send_op(oit_pkg::KIND_ACK, '1, '1, 1'b1);
        send_op(oit_pkg::KIND_CANCEL, '1, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_FIND_X, 64'd0, '1, 1'b0);
        send_op(oit_pkg::KIND_FIND_X, 64'd0, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_CLOSE, '1, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_CANCEL, '1, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_FIND_C, '1, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_ACK, 64'd1, 64'd9, 1'b0);
        send_op(oit_pkg::KIND_ACK, 64'd1, 64'd9, 1'b1);
        send_op(oit_pkg::KIND_ACK, 64'd0, 64'd9, 1'b1);
        send_op(oit_pkg::KIND_CLOSE, 64'd0, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_FIND_C, 64'd77, 64'd0, 1'b0);
        send_op(3'd6, '1, '1, 1'b1);
        send_op(3'd7, 64'd1, 64'd0, 1'b0);
    endtask

    // fill past capacity, so eviction of done entries and exhaustion occur
    task automatic test_fill_and_evict();
        for (int i = 0; i < 70; i++) begin
            send_op(oit_pkg::KIND_ADD, 64'h1000 + i, 64'd0, 1'b0);
            idle_gap();
        end
        send_op(oit_pkg::KIND_CLOSE, 64'h1020, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_CLOSE, 64'h1005, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_ADD, 64'h2000, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_ADD, 64'h2001, 64'd0, 1'b0);
        send_op(oit_pkg::KIND_ADD, 64'h2002, 64'd0, 1'b0);
    endtask

    task automatic test_random(int count);
        oit_pkg::cmd_t c;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            c.kind = (r < 3) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
            c.client_id = ($urandom_range(0, 9) == 0) ? rand64() : id_pool[$urandom_range(0, 15)];
            c.exchange_id = ($urandom_range(0, 9) == 0) ? rand64() : xid_pool[$urandom_range(0, 7)];
            c.accepted = ($urandom_range(0, 3) != 0);
            send_cmd(c);
            idle_gap();
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_state[i] = oit_pkg::ST_EMPTY;
            tbl_client[i] = '0;
            tbl_exch[i] = '0;
            tbl_seq[i] = '0;
        end
        taken_cnt = '0;
        seq_next = 64'd1;
        for (int i = 0; i < 16; i++) id_pool[i] = (i == 0) ? 64'd0 : rand64();
        for (int i = 0; i < 8; i++) xid_pool[i] = (i == 0) ? 64'd0 : rand64();
        id_pool[1] = '1;
        xid_pool[1] = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_evict();
        test_random(850);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (3 * ENTRIES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_order_id_table: done, clean");
        else
            $display("tb_order_id_table: done, errors");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb_order_id_table: done, errors");
        $finish;
    end

endmodule

// ----- order_id_table.f -----
rtl/oit_pkg.sv
rtl/oit_cell.sv
rtl/order_id_table.sv
tb/tb_order_id_table.sv
